// ===== hw/rtl/dqsi_pkg.sv =====
// Shared types and codes for the bounded deque with sorted insert.
`timescale 1ns / 1ps

package dqsi_pkg;

   // Operation codes carried in the func field
   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_INSERT     = 3'd4,
      FUNC_DELETE     = 3'd5,
      FUNC_CLEAR      = 3'd6
   } func_type;

   // Status codes returned with every result beat
   localparam logic [2:0] STATUS_DONE      = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_DUP       = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   // Request beat
   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] new_value;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

   // Control broadcast to every cell of the row
   typedef struct packed {
      func_type op;
      logic     apply;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/dqsi_cell.sv =====
// One storage cell of the deque row: holds a value and an occupied flag.
`timescale 1ns / 1ps

module dqsi_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dqsi_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]  new_value,
   input  logic [DATA_WIDTH-1:0]  prev_value,
   input  logic                   prev_occ,
   input  logic [DATA_WIDTH-1:0]  next_value,
   input  logic                   next_occ,
   input  logic                   pass_in,
   output logic                   pass_out,
   output logic                   hit,
   output logic [DATA_WIDTH-1:0]  value_out,
   output logic                   occ_out
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  occ_ff;
   logic                  occ_in;
   logic                  less;
   logic                  stop;

   // Walk from the front: keep going while entries are smaller than the value
   assign less     = occ_ff && (value_ff < new_value);
   assign pass_out = pass_in && less;
   assign stop     = pass_in && !less;
   assign hit      = stop && occ_ff && (value_ff == new_value);

   // Next contents of this cell
   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      unique case (ctrl.op)
         dqsi_pkg::FUNC_PUSH_FRONT: begin
            value_in = prev_value;
            occ_in   = prev_occ;
         end
         dqsi_pkg::FUNC_PUSH_BACK: begin
            if (!occ_ff && prev_occ) begin
               value_in = new_value;
               occ_in   = 1'b1;
            end
         end
         dqsi_pkg::FUNC_POP_FRONT: begin
            value_in = next_value;
            occ_in   = next_occ;
         end
         dqsi_pkg::FUNC_POP_BACK: begin
            occ_in = occ_ff && next_occ;
         end
         dqsi_pkg::FUNC_INSERT: begin
            if (pass_out) begin
               value_in = value_ff;
            end else if (stop) begin
               value_in = new_value;
               occ_in   = 1'b1;
            end else begin
               value_in = prev_value;
               occ_in   = prev_occ;
            end
         end
         dqsi_pkg::FUNC_DELETE: begin
            if (!pass_out) begin
               value_in = next_value;
               occ_in   = next_occ;
            end
         end
         dqsi_pkg::FUNC_CLEAR: begin
            occ_in = 1'b0;
         end
         default: begin
            value_in = value_ff;
            occ_in   = occ_ff;
         end
      endcase
   end

   // Occupied flag is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (ctrl.apply) begin
         occ_ff <= occ_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (ctrl.apply) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;
   assign occ_out   = occ_ff;

endmodule

// ===== hw/rtl/bounded_deque_with_sorted_insert_core.sv =====
// Top level of the bounded deque with sorted insert: cell row, status and response register.
`timescale 1ns / 1ps

// Bounded double-ended queue of up to DEPTH values held in a row of cells,
// front at cell 0. Each request beat (func, new_value) on the req_ channel
// carries one operation: push or pop at either end, sorted insert, delete by
// value or clear. Every request yields exactly one response beat on the rsp_
// channel with a status code, front and back values, the count and an empty
// flag, all describing the queue after the operation.
// A request updates the cells when it is accepted; its response is then
// loaded into the output register, once that register is empty or being
// taken, and is valid from then on. Throughput: one operation per cycle
// while rsp_stall is low. The figure is set by the walk flag that ripples
// through the cell row: every cell compares and shifts in the same cycle.
// When the receiver stalls, the response register holds its beat, one more
// operation may be accepted and applied, and req_stall then rises until the
// held beat is taken.
// Reset (synchronous, active high) empties the queue and drops any pending
// beat. Cells need no clearing pass; only occupied flags are reset.
module bounded_deque_with_sorted_insert_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqsi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqsi_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0]  value   [DEPTH];
   logic [DATA_WIDTH-1:0]  prv_val [DEPTH];
   logic [DATA_WIDTH-1:0]  nxt_val [DEPTH];
   logic [DEPTH-1:0]       occ;
   logic [DEPTH-1:0]       prv_occ;
   logic [DEPTH-1:0]       nxt_occ;
   logic [DEPTH:0]         pass;
   logic [DEPTH-1:0]       hit;

   logic [DATA_WIDTH-1:0]  new_value;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   found;
   logic                   modify;
   logic [2:0]             status;
   dqsi_pkg::cell_ctrl_type ctrl;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [2:0]             status_ff;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   dqsi_pkg::rsp_type      rsp_ff;
   logic                   move;
   logic [DATA_WIDTH-1:0]  front;
   logic [DATA_WIDTH-1:0]  back;

   assign new_value = DATA_WIDTH'(req_data.new_value);
   assign accept    = req_valid && !req_stall;
   assign full      = occ[DEPTH-1];
   assign empty     = !occ[0];
   assign found     = |hit;
   assign pass[0]   = 1'b1;

   // Row of cells, each wired to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prv_val[i] = new_value;
         assign prv_occ[i] = 1'b1;
      end else begin : g_inner
         assign prv_val[i] = value[i-1];
         assign prv_occ[i] = occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign nxt_val[i] = '0;
         assign nxt_occ[i] = 1'b0;
      end else begin : g_body
         assign nxt_val[i] = value[i+1];
         assign nxt_occ[i] = occ[i+1];
      end

      dqsi_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (new_value),
         .prev_value (prv_val[i]),
         .prev_occ   (prv_occ[i]),
         .next_value (nxt_val[i]),
         .next_occ   (nxt_occ[i]),
         .pass_in    (pass[i]),
         .pass_out   (pass[i+1]),
         .hit        (hit[i]),
         .value_out  (value[i]),
         .occ_out    (occ[i])
      );
   end

   // Decode the request into a cell operation and its status
   always_comb begin
      ctrl.op = dqsi_pkg::FUNC_CLEAR;
      modify  = 1'b0;
      status  = dqsi_pkg::STATUS_DONE;
      unique case (req_data.func)
         dqsi_pkg::FUNC_PUSH_FRONT, dqsi_pkg::FUNC_PUSH_BACK: begin
            ctrl.op = (req_data.func == dqsi_pkg::FUNC_PUSH_FRONT) ?
                      dqsi_pkg::FUNC_PUSH_FRONT : dqsi_pkg::FUNC_PUSH_BACK;
            modify  = !full;
            status  = full ? dqsi_pkg::STATUS_FULL : dqsi_pkg::STATUS_DONE;
         end
         dqsi_pkg::FUNC_POP_FRONT, dqsi_pkg::FUNC_POP_BACK: begin
            ctrl.op = (req_data.func == dqsi_pkg::FUNC_POP_FRONT) ?
                      dqsi_pkg::FUNC_POP_FRONT : dqsi_pkg::FUNC_POP_BACK;
            modify  = !empty;
            status  = empty ? dqsi_pkg::STATUS_EMPTY : dqsi_pkg::STATUS_DONE;
         end
         dqsi_pkg::FUNC_INSERT: begin
            ctrl.op = dqsi_pkg::FUNC_INSERT;
            modify  = !found && !full;
            if (found) begin
               status = dqsi_pkg::STATUS_DUP;
            end else if (full) begin
               status = dqsi_pkg::STATUS_FULL;
            end
         end
         dqsi_pkg::FUNC_DELETE: begin
            ctrl.op = dqsi_pkg::FUNC_DELETE;
            modify  = !empty && found;
            if (empty) begin
               status = dqsi_pkg::STATUS_EMPTY;
            end else if (!found) begin
               status = dqsi_pkg::STATUS_NOT_FOUND;
            end
         end
         dqsi_pkg::FUNC_CLEAR: begin
            ctrl.op = dqsi_pkg::FUNC_CLEAR;
            modify  = 1'b1;
         end
         default: begin
            // unused code: nothing changes, status done
            modify = 1'b0;
         end
      endcase
      ctrl.apply = accept && modify;
   end

   // Entry count follows the operation
   always_comb begin
      count_in = count_ff;
      if (ctrl.apply) begin
         unique case (ctrl.op)
            dqsi_pkg::FUNC_PUSH_FRONT, dqsi_pkg::FUNC_PUSH_BACK,
            dqsi_pkg::FUNC_INSERT:
               count_in = count_ff + CNT_W'(1);
            dqsi_pkg::FUNC_POP_FRONT, dqsi_pkg::FUNC_POP_BACK,
            dqsi_pkg::FUNC_DELETE:
               count_in = count_ff - CNT_W'(1);
            dqsi_pkg::FUNC_CLEAR:
               count_in = '0;
            default:
               count_in = count_ff;
         endcase
      end
   end

   // Front and back views of the row
   assign front = occ[0] ? value[0] : '0;

   always_comb begin
      back = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ[i] && !nxt_occ[i]) begin
            back = back | value[i];
         end
      end
   end

   // Handshake: one operation in flight, then the response register
   assign move         = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign busy_in      = accept || (busy_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   assign req_stall    = busy_ff && rsp_valid_ff && rsp_stall;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Status of the operation and the response beat
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
      end
      if (move) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.front_value <= 32'(front);
         rsp_ff.back_value  <= 32'(back);
         rsp_ff.entry_count <= 5'(count_ff);
         rsp_ff.is_empty    <= (count_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Count agrees with the occupied flags
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(occ)))
      else $error("entry count differs from occupied cells");

   // Occupied cells form one run from the front
   a_occ_contiguous : assert property (@(posedge clock) disable iff (reset)
      ((occ + DEPTH'(1)) & occ) == '0)
      else $error("occupied cells are not contiguous");

   // The walk stops at one cell at most
   a_single_hit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("more than one cell matched the walk");

   // An accepted beat always turns into a pending operation
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted beat not held for response");

endmodule
